@@ rtl/hybrid_logical_clock_assert.svh @@
// assertion macros for the hybrid logical clock rtl
`ifndef HYBRID_LOGICAL_CLOCK_ASSERT_SVH
`define HYBRID_LOGICAL_CLOCK_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define HLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hybrid logical clock check failed");

// next-cycle implication, disabled while reset is active
`define HLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hybrid logical clock check failed");

`endif

@@ rtl/hlc_pkg.sv @@
package hlc_pkg;

    localparam int PHYS_W    = 48;
    localparam int LOGICAL_W = 16;
    localparam int TS_W      = PHYS_W + LOGICAL_W;

    // s_tdata: wall_clock_ms, then sender_stamp
    localparam int S_TDATA_W = PHYS_W + TS_W;
    localparam int M_TDATA_W = TS_W;

    localparam logic [LOGICAL_W-1:0] LOGICAL_MAX = '1;

    typedef logic [PHYS_W-1:0]    phys_t;
    typedef logic [LOGICAL_W-1:0] logical_t;
    typedef logic [TS_W-1:0]      stamp_t;

    typedef enum logic {
        OP_LOCAL   = 1'b0,
        OP_RECEIVE = 1'b1
    } op_t;

    // architectural clock state
    typedef struct packed {
        stamp_t clock_value;
        phys_t  last_physical;
        phys_t  wall_at_last_change;
    } hlc_state_t;

endpackage

@@ rtl/hlc_core.sv @@
module hlc_core (
    input  hlc_pkg::op_t       operation,
    input  hlc_pkg::phys_t     wall_clock_ms,
    input  hlc_pkg::stamp_t    sender_stamp,
    input  hlc_pkg::hlc_state_t state,
    output hlc_pkg::hlc_state_t state_next
);

    hlc_pkg::phys_t    cur_ph;
    hlc_pkg::logical_t cur_lg;
    hlc_pkg::phys_t    snd_ph;
    hlc_pkg::logical_t snd_lg;
    hlc_pkg::phys_t    max_cs;
    hlc_pkg::phys_t    max_all;
    hlc_pkg::phys_t    wall_delta;
    hlc_pkg::phys_t    catch_ph;
    hlc_pkg::phys_t    base_ph;
    hlc_pkg::logical_t base_lg;
    logic              do_inc;
    logic              eq_c;
    logic              eq_s;
    hlc_pkg::phys_t    inc_ph;
    hlc_pkg::phys_t    phys_delta;
    hlc_pkg::phys_t    new_ph;
    hlc_pkg::logical_t new_lg;

    assign cur_ph = state.clock_value[hlc_pkg::TS_W-1:hlc_pkg::LOGICAL_W];
    assign cur_lg = state.clock_value[hlc_pkg::LOGICAL_W-1:0];
    assign snd_ph = sender_stamp[hlc_pkg::TS_W-1:hlc_pkg::LOGICAL_W];
    assign snd_lg = sender_stamp[hlc_pkg::LOGICAL_W-1:0];

    // catch-up terms depend only on state and wall, so they run in parallel
    assign wall_delta = (wall_clock_ms > state.wall_at_last_change)
                      ? wall_clock_ms - state.wall_at_last_change : '0;
    assign catch_ph   = state.last_physical + wall_delta;

    assign max_cs  = (cur_ph > snd_ph) ? cur_ph : snd_ph;
    assign max_all = (wall_clock_ms > max_cs) ? wall_clock_ms : max_cs;
    assign eq_c    = (max_all == cur_ph);
    assign eq_s    = (max_all == snd_ph);

    always_comb
    begin
        base_ph = max_all;
        base_lg = '0;
        do_inc  = 1'b0;
        unique case (operation)
            hlc_pkg::OP_LOCAL:
            begin
                do_inc  = (cur_ph >= wall_clock_ms);
                base_ph = do_inc ? cur_ph : wall_clock_ms;
                base_lg = cur_lg;
            end
            hlc_pkg::OP_RECEIVE:
            begin
                base_ph = max_all;
                do_inc  = eq_c | eq_s;
                if (eq_c && eq_s)
                    base_lg = (cur_lg > snd_lg) ? cur_lg : snd_lg;
                else if (eq_c)
                    base_lg = cur_lg;
                else
                    base_lg = snd_lg;
            end
            default:
            begin
                base_ph = max_all;
            end
        endcase
    end

    // logical increment with carry into the physical part, then catch-up
    assign inc_ph     = base_ph + hlc_pkg::PHYS_W'(base_lg == hlc_pkg::LOGICAL_MAX);
    assign phys_delta = inc_ph - state.last_physical;

    always_comb
    begin
        if (do_inc)
        begin
            new_lg = base_lg + hlc_pkg::LOGICAL_W'(1);
            new_ph = (phys_delta < wall_delta) ? catch_ph : inc_ph;
        end
        else
        begin
            new_lg = '0;
            new_ph = base_ph;
        end
    end

    always_comb
    begin
        state_next.clock_value         = {new_ph, new_lg};
        state_next.last_physical       = state.last_physical;
        state_next.wall_at_last_change = state.wall_at_last_change;
        if (new_ph != state.last_physical)
        begin
            state_next.last_physical       = new_ph;
            state_next.wall_at_last_change = wall_clock_ms;
        end
    end

endmodule

@@ rtl/hybrid_logical_clock.sv @@
// hybrid logical clock: keeps a 64-bit timestamp (48-bit physical milliseconds in the top
// bits, 16-bit logical count in the low bits) and returns one new timestamp per input
// transfer. tuser selects a local timestamp request (0) or a receive update against the
// sender's timestamp (1); the wall clock travels with every transfer. one transfer is
// accepted every clock cycle while the output side keeps up; each result passes through the
// input register, then the result register, before it is offered. the clock state is
// updated as each item leaves the input register, and the next item reads it straight
// away. the result register lets a new transfer in while a result still waits.
// reset clears the clock to zero.
`include "hybrid_logical_clock_assert.svh"

module hybrid_logical_clock (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hlc_pkg::S_TDATA_W-1:0] s_tdata,  // wall_clock_ms[47:0], sender_stamp[111:48]
    input  logic [0:0]                    s_tuser,  // operation[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hlc_pkg::M_TDATA_W-1:0] m_tdata   // timestamp[63:0]
);

    // input stage
    logic                in_vld_reg;
    logic                in_vld_next;
    hlc_pkg::op_t        op_reg;
    hlc_pkg::phys_t      wall_reg;
    hlc_pkg::stamp_t     sts_reg;

    // clock state
    hlc_pkg::hlc_state_t state_reg;
    hlc_pkg::hlc_state_t state_next;

    // result stage
    logic                out_vld_reg;
    logic                out_vld_next;
    hlc_pkg::stamp_t     out_data_reg;

    logic                advance;
    logic                in_take;

    // views used by the checks below
    hlc_pkg::phys_t      clock_ph;
    logic                local_behind;

    // the item in the input register moves on once the result register is free or its result is being taken
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    hlc_core u_core (
        .operation      (op_reg),
        .wall_clock_ms  (wall_reg),
        .sender_stamp   (sts_reg),
        .state          (state_reg),
        .state_next     (state_next)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= hlc_pkg::op_t'(s_tuser[0]);
            wall_reg <= s_tdata[hlc_pkg::PHYS_W-1:0];
            sts_reg  <= s_tdata[hlc_pkg::S_TDATA_W-1:hlc_pkg::PHYS_W];
        end
        if (advance)
            out_data_reg <= state_next.clock_value;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    assign clock_ph     = state_reg.clock_value[hlc_pkg::TS_W-1:hlc_pkg::LOGICAL_W];
    assign local_behind = advance && (op_reg == hlc_pkg::OP_LOCAL)
                       && (wall_reg > state_reg.last_physical);

    // every processed item yields a result in the next cycle
    `HLC_ASSERT_NEXT(a_result_follows, clk, rst_n, advance, m_tvalid)
    // the result presented is the clock just committed
    `HLC_ASSERT_NEXT(a_result_is_clock, clk, rst_n, advance, m_tdata == state_reg.clock_value)
    // tracked physical part always mirrors the clock's physical part
    `HLC_ASSERT_NOW(a_phys_tracked, clk, rst_n, 1'b1, state_reg.last_physical == clock_ph)
    // a local request behind the wall clock restarts the logical count
    `HLC_ASSERT_NEXT(a_local_reset, clk, rst_n, local_behind, m_tdata[hlc_pkg::LOGICAL_W-1:0] == '0)

endmodule

@@ dv/hybrid_logical_clock_tb.sv @@
module hybrid_logical_clock_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one row of the directed table; the expected stamp is only typed in where it is obvious
    typedef struct {
        hlc_pkg::op_t    op;
        hlc_pkg::phys_t  wall;
        hlc_pkg::stamp_t sender;
        bit              typed;
        hlc_pkg::stamp_t stamp;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [hlc_pkg::S_TDATA_W-1:0] s_tdata;   // wall_clock_ms[47:0], sender_stamp[111:48]
    logic [0:0]                    s_tuser;   // operation[0]
    logic                          m_tvalid;
    logic                          m_tready;
    logic [hlc_pkg::M_TDATA_W-1:0] m_tdata;   // timestamp[63:0]

    // predicted clock state, advanced once per accepted input transfer
    hlc_pkg::stamp_t clock_now;
    hlc_pkg::phys_t  last_phys;
    hlc_pkg::phys_t  wall_at_change;

    // stamps still owed by the block, oldest first
    hlc_pkg::stamp_t pending_stamps[$];
    stim_row_t       directed_rows[$];
    int unsigned     stamp_errors;

    // idling percentages of the current phase
    int unsigned send_idle_pct;
    int unsigned stall_pct;

    // long output hold-off, requested once by the stimulus process
    bit          hold_request;
    bit          hold_done;
    int unsigned hold_left;

    hlc_pkg::stamp_t want_stamp;

    hybrid_logical_clock uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // logical advance with carry into the physical part and the wall-clock catch-up
    function automatic void bump_logical(inout hlc_pkg::logical_t lg,
                                         inout hlc_pkg::phys_t ph,
                                         input hlc_pkg::phys_t wall);
        hlc_pkg::phys_t phys_gap;
        hlc_pkg::phys_t wall_gap;
        lg = lg + hlc_pkg::logical_t'(1);
        if (lg == '0)
        begin
            ph = ph + hlc_pkg::phys_t'(1);
        end
        phys_gap = ph - last_phys;
        wall_gap = (wall > wall_at_change) ? wall - wall_at_change : '0;
        // physical part must have moved at least as far as the wall clock has
        if (phys_gap < wall_gap)
        begin
            ph = last_phys + wall_gap;
        end
    endfunction

    // works out the stamp for one transfer and moves the predicted clock on
    function automatic hlc_pkg::stamp_t next_stamp(hlc_pkg::op_t op, hlc_pkg::phys_t wall,
                                                   hlc_pkg::stamp_t sender);
        hlc_pkg::phys_t    cur_ph;
        hlc_pkg::logical_t cur_lg;
        hlc_pkg::phys_t    snd_ph;
        hlc_pkg::logical_t snd_lg;
        hlc_pkg::phys_t    ph;
        hlc_pkg::logical_t lg;
        cur_ph = clock_now[hlc_pkg::TS_W-1:hlc_pkg::LOGICAL_W];
        cur_lg = clock_now[hlc_pkg::LOGICAL_W-1:0];
        snd_ph = sender[hlc_pkg::TS_W-1:hlc_pkg::LOGICAL_W];
        snd_lg = sender[hlc_pkg::LOGICAL_W-1:0];
        if (op == hlc_pkg::OP_LOCAL)
        begin
            ph = cur_ph;
            lg = cur_lg;
            if (cur_ph >= wall)
            begin
                bump_logical(lg, ph, wall);
            end
            else
            begin
                ph = wall;
                lg = '0;
            end
        end
        else
        begin
            ph = (cur_ph > snd_ph) ? cur_ph : snd_ph;
            if (wall > ph)
            begin
                ph = wall;
            end
            if (ph == cur_ph && ph == snd_ph)
            begin
                lg = (cur_lg > snd_lg) ? cur_lg : snd_lg;
                bump_logical(lg, ph, wall);
            end
            else if (ph == cur_ph)
            begin
                lg = cur_lg;
                bump_logical(lg, ph, wall);
            end
            else if (ph == snd_ph)
            begin
                lg = snd_lg;
                bump_logical(lg, ph, wall);
            end
            else
            begin
                lg = '0;
            end
        end
        clock_now = {ph, lg};
        if (last_phys != ph)
        begin
            last_phys      = ph;
            wall_at_change = wall;
        end
        return clock_now;
    endfunction

    task automatic add_row(hlc_pkg::op_t op, hlc_pkg::phys_t wall, hlc_pkg::stamp_t sender,
                           bit typed, hlc_pkg::stamp_t stamp);
        stim_row_t row;
        row.op     = op;
        row.wall   = wall;
        row.sender = sender;
        row.typed  = typed;
        row.stamp  = stamp;
        directed_rows.push_back(row);
    endtask

    // offers one input transfer, waits for it to be taken and books the stamp it owes
    task automatic offer_item(hlc_pkg::op_t op, hlc_pkg::phys_t wall, hlc_pkg::stamp_t sender,
                              bit typed, hlc_pkg::stamp_t stamp);
        hlc_pkg::stamp_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sender, wall};
        s_tuser  <= op;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predicted = next_stamp(op, wall, sender);
        pending_stamps.push_back(typed ? stamp : predicted);
    endtask

    // output side: random stalls, plus one long hold-off to fill the block up
    initial
    begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 60;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // each output transfer is matched against the oldest stamp still owed
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_stamps.size() == 0)
            begin
                stamp_errors++;
                if (stamp_errors <= 10)
                begin
                    $display("unexpected output transfer: timestamp %h", m_tdata);
                end
            end
            else
            begin
                want_stamp = pending_stamps.pop_front();
                if (m_tdata !== want_stamp)
                begin
                    stamp_errors++;
                    if (stamp_errors <= 10)
                    begin
                        $display("timestamp mismatch: expected %h, got %h", want_stamp, m_tdata);
                    end
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("hybrid_logical_clock test failed");
        $finish;
    end

    initial
    begin
        int unsigned       idle_by_phase[4];
        int unsigned       stall_by_phase[4];
        int unsigned       kind;
        hlc_pkg::op_t      op;
        hlc_pkg::phys_t    wall;
        hlc_pkg::phys_t    wall_now;
        hlc_pkg::phys_t    snd_ph;
        hlc_pkg::logical_t snd_lg;
        hlc_pkg::stamp_t   sender;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        clock_now      = '0;
        last_phys      = '0;
        wall_at_change = '0;
        stamp_errors   = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_request   = 1'b0;
        idle_by_phase  = '{0, 65, 0, 23};
        stall_by_phase = '{0, 0, 65, 23};

        // first stamp after reset: clock already level with a zero wall clock
        add_row(hlc_pkg::OP_LOCAL, 48'h0, 64'h0, 1'b1, 64'h0000_0000_0000_0001);
        // wall clock at its top value takes over with logical zero
        add_row(hlc_pkg::OP_LOCAL, 48'hFFFF_FFFF_FFFF, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_0000);
        // logical wrap carries into a full physical part, which wraps to zero
        add_row(hlc_pkg::OP_RECEIVE, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0);
        // sender ahead: its logical part is advanced
        add_row(hlc_pkg::OP_RECEIVE, 48'h5, 64'h0000_0000_0100_0007, 1'b1,
                64'h0000_0000_0100_0008);
        // wall clock ahead of both: logical part cleared
        add_row(hlc_pkg::OP_RECEIVE, 48'h200, 64'h0, 1'b1, 64'h0000_0000_0200_0000);
        add_row(hlc_pkg::OP_RECEIVE, 48'h210, 64'h0000_0000_1000_0003, 1'b1,
                64'h0000_0000_1000_0004);
        // local request with catch-up to the wall clock's progress
        add_row(hlc_pkg::OP_LOCAL, 48'h300, 64'h0, 1'b1, 64'h0000_0000_10F0_0005);
        // both physical parts equal: larger logical part wins
        add_row(hlc_pkg::OP_RECEIVE, 48'h300, 64'h0000_0000_10F0_0009, 1'b1,
                64'h0000_0000_10F0_000A);
        // clock ahead of sender, with a one millisecond catch-up
        add_row(hlc_pkg::OP_RECEIVE, 48'h301, 64'h0000_0000_0010_FFFF, 1'b1,
                64'h0000_0000_10F1_000B);
        // logical wrap on receive carries one into the physical part
        add_row(hlc_pkg::OP_RECEIVE, 48'h301, 64'h0000_0000_10F1_FFFF, 1'b1,
                64'h0000_0000_10F2_0000);
        // sender field must be ignored on a local request
        add_row(hlc_pkg::OP_LOCAL, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0);
        add_row(hlc_pkg::OP_RECEIVE, 48'hFFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'h0);
        add_row(hlc_pkg::OP_LOCAL, 48'hFFFF_FFFF_FFFF, 64'h0, 1'b0, 64'h0);
        add_row(hlc_pkg::OP_RECEIVE, 48'h0, 64'h0, 1'b0, 64'h0);
        add_row(hlc_pkg::OP_RECEIVE, 48'h8000_0000_0000, 64'hAAAA_5555_AAAA_5555, 1'b0, 64'h0);
        add_row(hlc_pkg::OP_LOCAL, 48'h5555_5555_5555, 64'h5555_AAAA_5555_AAAA, 1'b0, 64'h0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i].op, directed_rows[i].wall, directed_rows[i].sender,
                       directed_rows[i].typed, directed_rows[i].stamp);
        end

        // random part: a slowly moving wall clock and senders close to the clock,
        // so that ties, wraps and catch-ups keep coming up
        wall_now = clock_now[hlc_pkg::TS_W-1:hlc_pkg::LOGICAL_W];
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = idle_by_phase[phase];
            stall_pct     = stall_by_phase[phase];
            for (int n = 0; n < 100; n++)
            begin
                // sender runs flat out here, so the hold-off backs the block up
                if (phase == 0 && n == 40)
                begin
                    hold_request = 1'b1;
                end
                kind = $urandom_range(0, 99);
                op   = $urandom_range(0, 1) ? hlc_pkg::OP_RECEIVE : hlc_pkg::OP_LOCAL;
                if (kind < 10)
                begin
                    // noise over the whole field range
                    wall   = hlc_pkg::phys_t'({$urandom, $urandom});
                    sender = {$urandom, $urandom};
                end
                else
                begin
                    if (kind < 13)
                    begin
                        // wall clock close to the wrap of the physical part
                        wall_now = 48'hFFFF_FFFF_FFF0
                                 + hlc_pkg::phys_t'($urandom_range(0, 15));
                    end
                    else if (kind < 18)
                    begin
                        // wall clock stepping backwards
                        wall_now = wall_now - hlc_pkg::phys_t'($urandom_range(0, 8));
                    end
                    else
                    begin
                        wall_now = wall_now + hlc_pkg::phys_t'($urandom_range(0, 3));
                    end
                    wall   = wall_now;
                    snd_ph = clock_now[hlc_pkg::TS_W-1:hlc_pkg::LOGICAL_W]
                           + hlc_pkg::phys_t'($urandom_range(0, 6)) - hlc_pkg::phys_t'(3);
                    case ($urandom_range(0, 3))
                        0:       snd_lg = hlc_pkg::LOGICAL_MAX;
                        1:       snd_lg = hlc_pkg::LOGICAL_MAX - hlc_pkg::logical_t'(1);
                        2:       snd_lg = clock_now[hlc_pkg::LOGICAL_W-1:0];
                        default: snd_lg = hlc_pkg::logical_t'($urandom);
                    endcase
                    sender = {snd_ph, snd_lg};
                end
                offer_item(op, wall, sender, 1'b0, '0);
            end
        end

        @(negedge clk);
        s_tvalid      <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;

        // drain, then keep watching the output side for any stray transfer
        while (pending_stamps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (stamp_errors == 0)
        begin
            $display("hybrid_logical_clock test passed");
        end
        else
        begin
            $display("hybrid_logical_clock test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hlc_pkg.sv
rtl/hlc_core.sv
rtl/hybrid_logical_clock.sv
dv/hybrid_logical_clock_tb.sv
